// ===== src/tts_pkg.sv =====
`default_nettype none
package tts_pkg;

  localparam int NumSlotsDef   = 8;
  localparam int TickBitsDef   = 16;
  localparam int HandleBitsDef = 8;
  localparam int RunBitsDef    = 8;

  // Upper bound on the tasks that one dispatch pass hands out.
  localparam int MaxResults = 8;

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_DEL  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;
  localparam logic [1:0] CMD_DISP = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  slot;
    logic [7:0]  handle;
    logic [15:0] delay;
    logic [15:0] period;
  } tts_in_t;

  typedef struct packed {
    logic [7:0] task_handle;
    logic [2:0] task_slot;
    logic       last;
  } tts_out_t;

  typedef struct packed {
    logic emit;
    logic one_shot;
    logic found;
  } tts_stat_t;

endpackage
`default_nettype wire

// ===== src/tts_cell.sv =====
`default_nettype none
module tts_cell import tts_pkg::*; #(
  parameter int TICK_BITS   = TickBitsDef,
  parameter int HANDLE_BITS = HandleBitsDef,
  parameter int RUN_BITS    = RunBitsDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   shift_i,
  input  wire logic [HANDLE_BITS-1:0] handle_i,
  input  wire logic [TICK_BITS-1:0]   delay_i,
  input  wire logic [TICK_BITS-1:0]   period_i,
  input  wire logic [RUN_BITS-1:0]    pending_i,
  output logic      [HANDLE_BITS-1:0] handle_o,
  output logic      [TICK_BITS-1:0]   delay_o,
  output logic      [TICK_BITS-1:0]   period_o,
  output logic      [RUN_BITS-1:0]    pending_o
);

  logic [HANDLE_BITS-1:0] handle_q;
  logic [TICK_BITS-1:0]   delay_q;
  logic [TICK_BITS-1:0]   period_q;
  logic [RUN_BITS-1:0]    pending_q;

  // Handle and run count come out of reset cleared, so every slot starts empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      handle_q  <= '0;
      pending_q <= '0;
    end else if (shift_i) begin
      handle_q  <= handle_i;
      pending_q <= pending_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      delay_q  <= delay_i;
      period_q <= period_i;
    end
  end

  assign handle_o  = handle_q;
  assign delay_o   = delay_q;
  assign period_o  = period_q;
  assign pending_o = pending_q;

endmodule
`default_nettype wire

// ===== src/tts_head.sv =====
`default_nettype none
module tts_head import tts_pkg::*; #(
  parameter int NUM_SLOTS   = NumSlotsDef,
  parameter int TICK_BITS   = TickBitsDef,
  parameter int HANDLE_BITS = HandleBitsDef,
  parameter int RUN_BITS    = RunBitsDef,
  localparam int SlotW      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
  localparam int CmpW       = (SlotW > 3) ? SlotW : 3
) (
  input  wire logic [1:0]             cmd_i,
  input  wire logic [2:0]             slot_i,
  input  wire logic [HANDLE_BITS-1:0] key_i,
  input  wire logic [TICK_BITS-1:0]   delay_i,
  input  wire logic [TICK_BITS-1:0]   period_i,
  input  wire logic [SlotW-1:0]       step_i,
  input  wire logic                   done_i,
  input  wire logic                   full_i,
  input  wire logic [HANDLE_BITS-1:0] rec_handle_i,
  input  wire logic [TICK_BITS-1:0]   rec_delay_i,
  input  wire logic [TICK_BITS-1:0]   rec_period_i,
  input  wire logic [RUN_BITS-1:0]    rec_pending_i,
  output logic      [HANDLE_BITS-1:0] rec_handle_o,
  output logic      [TICK_BITS-1:0]   rec_delay_o,
  output logic      [TICK_BITS-1:0]   rec_period_o,
  output logic      [RUN_BITS-1:0]    rec_pending_o,
  output tts_stat_t                   stat_o
);

  // The record leaving the front cell is the slot whose index is step_i.
  always_comb begin
    rec_handle_o  = rec_handle_i;
    rec_delay_o   = rec_delay_i;
    rec_period_o  = rec_period_i;
    rec_pending_o = rec_pending_i;
    stat_o        = '0;
    case (cmd_i)
      CMD_ADD: begin
        if (CmpW'(slot_i) == CmpW'(step_i) && key_i != '0) begin
          rec_handle_o  = key_i;
          rec_delay_o   = delay_i;
          rec_period_o  = period_i;
          rec_pending_o = '0;
        end
      end
      CMD_DEL: begin
        if (!done_i && rec_handle_i == key_i) begin
          rec_handle_o = '0;
          stat_o.found = 1'b1;
        end
      end
      CMD_TICK: begin
        if (rec_handle_i != '0) begin
          if (rec_delay_i != '0) begin
            rec_delay_o = rec_delay_i - 1'b1;
          end else begin
            if (rec_pending_i != '1) begin
              rec_pending_o = rec_pending_i + 1'b1;
            end
            if (rec_period_i != '0) begin
              rec_delay_o = rec_period_i - 1'b1;
            end
          end
        end
      end
      default: begin
        if (rec_handle_i != '0 && rec_pending_i != '0 && !full_i) begin
          stat_o.emit     = 1'b1;
          stat_o.one_shot = (rec_period_i == '0);
          rec_pending_o   = rec_pending_i - 1'b1;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/time_triggered_task_scheduler_unit.sv =====
// Time-triggered task scheduler with a table of NUM_SLOTS priority slots.
// Input channel (in_valid_i, in_stall_o, in_data_i) takes one command per
// transfer: add, delete, tick or dispatch pass. Output channel (out_valid_o,
// out_stall_i, out_data_o) carries one transfer per task to run, in slot
// order, with last set on the final task of a pass.
// The slot records sit in a ring of cells. Every command rotates the whole
// ring once past a shared head stage. A dispatch pass rotates the ring,
// hands over its final task if any ran, runs one further rotation for each
// one-shot task it ran, which removes that task by handle, and then finishes.
// The first task of a pass waits in the holding stage and reaches the
// output register once the head has seen the next runnable slot or the
// pass has ended. in_stall_o is high while a command is in progress. A
// stall on the output holds the output register and, once the one-entry
// holding stage behind it is full too, pauses the rotation. Reset empties
// every slot and clears all pending runs; there is no clearing pass.
`default_nettype none
module time_triggered_task_scheduler_unit import tts_pkg::*; #(
  parameter int NUM_SLOTS   = NumSlotsDef,
  parameter int TICK_BITS   = TickBitsDef,
  parameter int HANDLE_BITS = HandleBitsDef,
  parameter int RUN_BITS    = RunBitsDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire tts_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output tts_out_t      out_data_o
);

  localparam int SlotW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CntW  = $clog2(MaxResults + 1);
  localparam int DqW   = (MaxResults > 1) ? $clog2(MaxResults) : 1;
  localparam logic [SlotW-1:0] LastStep = SlotW'(NUM_SLOTS - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROT   = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  // Ring of slot records.
  logic [HANDLE_BITS-1:0] c_h  [NUM_SLOTS];
  logic [TICK_BITS-1:0]   c_d  [NUM_SLOTS];
  logic [TICK_BITS-1:0]   c_p  [NUM_SLOTS];
  logic [RUN_BITS-1:0]    c_r  [NUM_SLOTS];
  logic [HANDLE_BITS-1:0] nx_h [NUM_SLOTS];
  logic [TICK_BITS-1:0]   nx_d [NUM_SLOTS];
  logic [TICK_BITS-1:0]   nx_p [NUM_SLOTS];
  logic [RUN_BITS-1:0]    nx_r [NUM_SLOTS];

  logic [HANDLE_BITS-1:0] hd_h;
  logic [TICK_BITS-1:0]   hd_d;
  logic [TICK_BITS-1:0]   hd_p;
  logic [RUN_BITS-1:0]    hd_r;
  tts_stat_t              stat;

  logic [1:0]             state_q, state_d;
  logic [1:0]             cmd_q, cmd_d;
  logic [2:0]             slot_q, slot_d;
  logic [HANDLE_BITS-1:0] key_q, key_d;
  logic [TICK_BITS-1:0]   delay_q, delay_d;
  logic [TICK_BITS-1:0]   period_q, period_d;
  logic [SlotW-1:0]       step_q, step_d;
  logic                   done_q, done_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   disp_q, disp_d;
  logic [CntW-1:0]        dq_cnt_q, dq_cnt_d;
  logic [CntW-1:0]        dq_rd_q, dq_rd_d;
  logic                   held_valid_q, held_valid_d;
  logic [7:0]             held_handle_q, held_handle_d;
  logic [2:0]             held_slot_q, held_slot_d;
  logic                   out_valid_q, out_valid_d;
  tts_out_t               out_data_q;

  logic [HANDLE_BITS-1:0] dq_mem [MaxResults];
  logic                   dq_we;
  logic                   dq_re;
  logic                   accept;
  logic                   out_free;
  logic                   out_load;
  logic                   out_last;
  logic                   advance;
  logic                   full;

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    if (k == NUM_SLOTS - 1) begin : g_tail
      assign nx_h[k] = hd_h;
      assign nx_d[k] = hd_d;
      assign nx_p[k] = hd_p;
      assign nx_r[k] = hd_r;
    end else begin : g_body
      assign nx_h[k] = c_h[k+1];
      assign nx_d[k] = c_d[k+1];
      assign nx_p[k] = c_p[k+1];
      assign nx_r[k] = c_r[k+1];
    end
    tts_cell #(
      .TICK_BITS   (TICK_BITS),
      .HANDLE_BITS (HANDLE_BITS),
      .RUN_BITS    (RUN_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .shift_i   (advance),
      .handle_i  (nx_h[k]),
      .delay_i   (nx_d[k]),
      .period_i  (nx_p[k]),
      .pending_i (nx_r[k]),
      .handle_o  (c_h[k]),
      .delay_o   (c_d[k]),
      .period_o  (c_p[k]),
      .pending_o (c_r[k])
    );
  end

  assign full = (cnt_q == CntW'(MaxResults));

  tts_head #(
    .NUM_SLOTS   (NUM_SLOTS),
    .TICK_BITS   (TICK_BITS),
    .HANDLE_BITS (HANDLE_BITS),
    .RUN_BITS    (RUN_BITS)
  ) u_head (
    .cmd_i         (cmd_q),
    .slot_i        (slot_q),
    .key_i         (key_q),
    .delay_i       (delay_q),
    .period_i      (period_q),
    .step_i        (step_q),
    .done_i        (done_q),
    .full_i        (full),
    .rec_handle_i  (c_h[0]),
    .rec_delay_i   (c_d[0]),
    .rec_period_i  (c_p[0]),
    .rec_pending_i (c_r[0]),
    .rec_handle_o  (hd_h),
    .rec_delay_o   (hd_d),
    .rec_period_o  (hd_p),
    .rec_pending_o (hd_r),
    .stat_o        (stat)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  // A second task cannot enter the holding stage until the first has moved on.
  assign advance    = (state_q == ST_ROT) && !(stat.emit && held_valid_q && !out_free);

  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    slot_d        = slot_q;
    key_d         = key_q;
    delay_d       = delay_q;
    period_d      = period_q;
    step_d        = step_q;
    done_d        = done_q;
    cnt_d         = cnt_q;
    disp_d        = disp_q;
    dq_cnt_d      = dq_cnt_q;
    dq_rd_d       = dq_rd_q;
    held_valid_d  = held_valid_q;
    held_handle_d = held_handle_q;
    held_slot_d   = held_slot_q;
    out_load      = 1'b0;
    out_last      = 1'b0;
    dq_we         = 1'b0;
    dq_re         = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d        = in_data_i.cmd;
          slot_d       = in_data_i.slot;
          key_d        = HANDLE_BITS'(in_data_i.handle);
          delay_d      = TICK_BITS'(in_data_i.delay);
          period_d     = TICK_BITS'(in_data_i.period);
          step_d       = '0;
          done_d       = 1'b0;
          cnt_d        = '0;
          disp_d       = (in_data_i.cmd == CMD_DISP);
          dq_cnt_d     = '0;
          dq_rd_d      = '0;
          held_valid_d = 1'b0;
          state_d      = ST_ROT;
        end
      end
      ST_ROT: begin
        if (advance) begin
          step_d = step_q + 1'b1;
          if (stat.found) begin
            done_d = 1'b1;
          end
          if (stat.emit) begin
            out_load      = held_valid_q;
            held_valid_d  = 1'b1;
            held_handle_d = 8'(c_h[0]);
            held_slot_d   = 3'(step_q);
            cnt_d         = cnt_q + 1'b1;
            if (stat.one_shot) begin
              dq_we    = 1'b1;
              dq_cnt_d = dq_cnt_q + 1'b1;
            end
          end
          if (step_q == LastStep) begin
            step_d  = '0;
            state_d = disp_q ? ST_FLUSH : ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (held_valid_q) begin
          if (out_free) begin
            out_load     = 1'b1;
            out_last     = 1'b1;
            held_valid_d = 1'b0;
          end
        end else if (dq_rd_q != dq_cnt_q) begin
          // Each one-shot task that ran is removed by its own handle search.
          cmd_d   = CMD_DEL;
          dq_re   = 1'b1;
          dq_rd_d = dq_rd_q + 1'b1;
          done_d  = 1'b0;
          step_d  = '0;
          state_d = ST_ROT;
        end else begin
          disp_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= '0;
      done_q       <= 1'b0;
      cnt_q        <= '0;
      disp_q       <= 1'b0;
      dq_cnt_q     <= '0;
      dq_rd_q      <= '0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      done_q       <= done_d;
      cnt_q        <= cnt_d;
      disp_q       <= disp_d;
      dq_cnt_q     <= dq_cnt_d;
      dq_rd_q      <= dq_rd_d;
      held_valid_q <= held_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q         <= cmd_d;
    slot_q        <= slot_d;
    if (dq_re) begin
      key_q <= dq_mem[dq_rd_q[DqW-1:0]];
    end else begin
      key_q <= key_d;
    end
    delay_q       <= delay_d;
    period_q      <= period_d;
    held_handle_q <= held_handle_d;
    held_slot_q   <= held_slot_d;
    if (out_load) begin
      out_data_q.task_handle <= held_handle_q;
      out_data_q.task_slot   <= held_slot_q;
      out_data_q.last        <= out_last;
    end
    if (dq_we) begin
      dq_mem[dq_cnt_q[DqW-1:0]] <= c_h[0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

// ===== tb/tb_time_triggered_task_scheduler_unit.sv =====
`default_nettype none
module tb_time_triggered_task_scheduler_unit;
  import tts_pkg::*;

  localparam int Slots = NumSlotsDef;
  localparam int ReportLimit = 10;
  localparam logic [RunBitsDef-1:0] RunsMax = {RunBitsDef{1'b1}};

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  tts_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  tts_out_t out_data;

  // Shadow copy of the slot table.
  logic [HandleBitsDef-1:0] slot_owner  [Slots];
  logic [TickBitsDef-1:0]   slot_wait   [Slots];
  logic [TickBitsDef-1:0]   slot_period [Slots];
  logic [RunBitsDef-1:0]    slot_runs   [Slots];

  tts_out_t runs_due [$];
  tts_out_t want;
  int       bad_runs = 0;
  int       burst_left = 1;
  logic [7:0] stall_pat = 8'h00;
  int       stall_left = 0;

  time_triggered_task_scheduler_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Empties the lowest slot holding the handle, which may not be the slot that ran.
  function automatic void free_first(input logic [HandleBitsDef-1:0] h);
    for (int i = 0; i < Slots; i++) begin
      if (slot_owner[i] == h) begin
        slot_owner[i] = '0;
        return;
      end
    end
  endfunction

  function automatic void schedule_cmd(input tts_in_t c);
    logic [7:0] ran_h [MaxResults];
    logic [2:0] ran_s [MaxResults];
    int         n;
    tts_out_t   r;
    n = 0;
    case (c.cmd)
      CMD_ADD: begin
        if (int'(c.slot) < Slots && c.handle != '0) begin
          slot_owner[c.slot]  = c.handle;
          slot_wait[c.slot]   = c.delay;
          slot_period[c.slot] = c.period;
          slot_runs[c.slot]   = '0;
        end
      end
      CMD_DEL: free_first(c.handle);
      CMD_TICK: begin
        for (int i = 0; i < Slots; i++) begin
          if (slot_owner[i] != '0) begin
            if (slot_wait[i] != '0) begin
              slot_wait[i] = slot_wait[i] - 1'b1;
            end else begin
              if (slot_runs[i] != RunsMax) slot_runs[i] = slot_runs[i] + 1'b1;
              if (slot_period[i] != '0) slot_wait[i] = slot_period[i] - 1'b1;
            end
          end
        end
      end
      CMD_DISP: begin
        for (int i = 0; i < Slots && n < MaxResults; i++) begin
          if (slot_owner[i] != '0 && slot_runs[i] != '0) begin
            ran_h[n] = slot_owner[i];
            ran_s[n] = 3'(i);
            n++;
            slot_runs[i] = slot_runs[i] - 1'b1;
            if (slot_period[i] == '0) free_first(ran_h[n-1]);
          end
        end
        for (int k = 0; k < n; k++) begin
          r.task_handle = ran_h[k];
          r.task_slot   = ran_s[k];
          r.last        = (k == n - 1);
          runs_due.push_back(r);
        end
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (runs_due.size() == 0) begin
        bad_runs++;
        if (bad_runs <= ReportLimit)
          $display("%0t: unexpected task run: handle %0d slot %0d last %0b", $time,
                   out_data.task_handle, out_data.task_slot, out_data.last);
      end else begin
        want = runs_due.pop_front();
        if (out_data.task_handle !== want.task_handle || out_data.task_slot !== want.task_slot
            || out_data.last !== want.last) begin
          bad_runs++;
          if (bad_runs <= ReportLimit)
            $display("%0t: expected handle %0d slot %0d last %0b, got handle %0d slot %0d last %0b",
                     $time, want.task_handle, want.task_slot, want.last,
                     out_data.task_handle, out_data.task_slot, out_data.last);
        end
      end
    end
  end

  // The receiver runs a rotating stall pattern that is renewed when a random run length expires.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(16, 64);
      case ($urandom_range(0, 3))
        0: stall_pat = 8'h00;
        1: stall_pat = 8'($urandom);
        2: stall_pat = 8'($urandom) & 8'($urandom);
        default: stall_pat = 8'($urandom) | 8'($urandom);
      endcase
    end
    stall_left--;
    stall_pat = {stall_pat[6:0], stall_pat[7]};
    out_stall <= stall_pat[0];
  end

  task automatic send_cmd(input logic [1:0] op, input logic [2:0] slot,
                          input logic [7:0] handle, input logic [15:0] delay,
                          input logic [15:0] period);
    tts_in_t item;
    int      gap;
    item.cmd    = op;
    item.slot   = slot;
    item.handle = handle;
    item.delay  = delay;
    item.period = period;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    schedule_cmd(item);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
      gap = $urandom_range(1, 20);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    if (in_valid) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    while (runs_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_handle();
    if ($urandom_range(0, 5) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(1, 10));
  endfunction

  function automatic logic [15:0] pick_ticks(input int hi);
    if ($urandom_range(0, 9) == 0) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(0, hi));
  endfunction

  task automatic test_periodic_extremes();
    send_cmd(CMD_ADD, 3'd0, 8'hFF, 16'h0000, 16'h0001);
    send_cmd(CMD_ADD, 3'd7, 8'h01, 16'hFFFF, 16'hFFFF);
    send_cmd(CMD_ADD, 3'd3, 8'h80, 16'h0001, 16'h0002);
    send_cmd(CMD_TICK, 3'd0, 8'h00, 16'h0000, 16'h0000);
    send_cmd(CMD_TICK, 3'd7, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_cmd(CMD_DISP, 3'd0, 8'h00, 16'h0000, 16'h0000);
    send_cmd(CMD_DISP, 3'd5, 8'hAA, 16'h5555, 16'hAAAA);
    // Nothing left to run, so this pass gives no transfer.
    send_cmd(CMD_DISP, 3'd0, 8'h00, 16'h0000, 16'h0000);
    wait_drained();
  endtask

  // A one-shot in a higher slot shares its handle with a lower slot, so its removal
  // empties the lower slot and leaves the one-shot to run again.
  task automatic test_one_shot_duplicates();
    send_cmd(CMD_ADD, 3'd2, 8'h05, 16'hFFFF, 16'h0007);
    send_cmd(CMD_ADD, 3'd5, 8'h05, 16'h0000, 16'h0000);
    send_cmd(CMD_TICK, 3'd0, 8'h00, 16'h0000, 16'h0000);
    send_cmd(CMD_DISP, 3'd0, 8'h00, 16'h0000, 16'h0000);
    send_cmd(CMD_TICK, 3'd0, 8'h00, 16'h0000, 16'h0000);
    send_cmd(CMD_DISP, 3'd0, 8'h00, 16'h0000, 16'h0000);
    wait_drained();
  endtask

  task automatic test_delete_and_overwrite();
    send_cmd(CMD_TICK, 3'd0, 8'h00, 16'h0000, 16'h0000);
    send_cmd(CMD_DEL, 3'd0, 8'hFF, 16'h0000, 16'h0000);
    send_cmd(CMD_DEL, 3'd0, 8'h42, 16'h0000, 16'h0000);
    send_cmd(CMD_DEL, 3'd0, 8'h00, 16'h0000, 16'h0000);
    send_cmd(CMD_TICK, 3'd0, 8'h00, 16'h0000, 16'h0000);
    send_cmd(CMD_ADD, 3'd3, 8'h7E, 16'h0000, 16'h0000);
    send_cmd(CMD_ADD, 3'd0, 8'h01, 16'h0002, 16'h0003);
    send_cmd(CMD_ADD, 3'd4, 8'h00, 16'h0003, 16'h0003);
    send_cmd(CMD_TICK, 3'd0, 8'h00, 16'h0000, 16'h0000);
    send_cmd(CMD_DISP, 3'd0, 8'h00, 16'h0000, 16'h0000);
    send_cmd(CMD_DISP, 3'd0, 8'h00, 16'h0000, 16'h0000);
    wait_drained();
  endtask

  task automatic test_pending_saturation();
    send_cmd(CMD_ADD, 3'd6, 8'h66, 16'h0000, 16'h0001);
    repeat (260) send_cmd(CMD_TICK, 3'd0, 8'h00, 16'h0000, 16'h0000);
    send_cmd(CMD_DISP, 3'd0, 8'h00, 16'h0000, 16'h0000);
    wait_drained();
  endtask

  task automatic test_random(input int count);
    int         sel;
    logic [1:0] op;
    logic [7:0] h;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 25) op = CMD_ADD;
      else if (sel < 33) op = CMD_DEL;
      else if (sel < 75) op = CMD_TICK;
      else op = CMD_DISP;
      h = pick_handle();
      // Most deletes take their handle from a randomly chosen slot of the table, which may be empty.
      if (op == CMD_DEL && $urandom_range(0, 3) != 0) h = slot_owner[$urandom_range(0, Slots - 1)];
      send_cmd(op, 3'($urandom_range(0, 7)), h, pick_ticks(6), pick_ticks(4));
      if (k % 75 == 74) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < Slots; i++) begin
      slot_owner[i]  = '0;
      slot_wait[i]   = '0;
      slot_period[i] = '0;
      slot_runs[i]   = '0;
    end
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    test_periodic_extremes();
    test_one_shot_duplicates();
    test_delete_and_overwrite();
    test_pending_saturation();
    test_random(95);
    repeat (200) @(posedge clk);
    if (bad_runs == 0 && runs_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== time_triggered_task_scheduler_unit.f =====
src/tts_pkg.sv
src/tts_cell.sv
src/tts_head.sv
src/time_triggered_task_scheduler_unit.sv
tb/tb_time_triggered_task_scheduler_unit.sv
